/* rtl/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, selection codes and stage records for the point to segment
// squared distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 33;

    // Projection divider: |num| < 2^50, den < 2^33, |quotient| < 2^17.
    localparam int NUM1_W = 51;
    localparam int DEN1_W = 33;
    localparam int QUO1_W = 18;

    // Second-axis divider: |num| < 2^32, divisor < 2^16, quotient < 2^16.
    localparam int NUM2_W = 33;
    localparam int DEN2_W = 17;
    localparam int QUO2_W = 17;

    localparam logic [DIST_W-1:0] DIST_MAX = 33'd8589672450;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Which point the projection settles on.
    typedef enum logic [1:0] {
        SEL_LEFT,
        SEL_RIGHT,
        SEL_MID
    } psd_sel_t;

    // Carried alongside the projection divider.
    typedef struct packed {
        logic                degen;
        logic                neg;
        coord_t              x1;
        coord_t              y1;
        coord_t              x2;
        coord_t              y2;
        coord_t              qx;
        coord_t              qy;
        logic [16:0]         dx;
        logic signed [16:0]  dy;
    } psd_side1_t;

    // Carried alongside the second-axis divider.
    typedef struct packed {
        logic     degen;
        psd_sel_t sel;
        logic     use_x;
        logic     neg;
        coord_t   x;
        coord_t   x1;
        coord_t   y1;
        coord_t   x2;
        coord_t   y2;
        coord_t   qx;
        coord_t   qy;
    } psd_side2_t;

endpackage

`default_nettype wire

/* rtl/psd_div.sv */
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels with each request. The caller guarantees num < den * 2^QUO_W.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_div
    import psd_pkg::*;
#(
    parameter int NUM_W  = NUM1_W,
    parameter int DEN_W  = DEN1_W,
    parameter int QUO_W  = QUO1_W,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [0:QUO_W];
    logic [DEN_W-1:0]  rem_reg  [0:QUO_W];
    logic [QUO_W-1:0]  low_reg  [0:QUO_W];
    logic [DEN_W-1:0]  den_reg  [0:QUO_W];
    logic [SIDE_W-1:0] side_reg [0:QUO_W];

    // Load stage: the upper dividend bits form the starting remainder.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= DEN_W'(in_num >> QUO_W);
            low_reg[0]  <= in_num[QUO_W-1:0];
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    // One shift, compare and subtract per stage.
    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb begin
            trial = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
            diff  = trial - {1'b0, den_reg[k-1]};
            ge    = (trial >= {1'b0, den_reg[k-1]});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                low_reg[k]  <= {low_reg[k-1][QUO_W-2:0], ge};
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign out_quo   = low_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

`default_nettype wire

/* rtl/point_segment_distance_sq_unit.sv */
// ----------------------------------------------------------------------------
// point_segment_distance_sq_unit
// Squared distance from a query point to a segment, clamped to the segment's
// ends, computed in a fully pipelined datapath with two pipelined dividers.
// ----------------------------------------------------------------------------
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_ax s_ay s_bx s_by s_px s_py
//   m_        out        m_valid/m_ready    m_dist_sq
//
// One request enters per cycle while the output does not stall; it passes the
// 19 stages of the projection divider and the 18 of the second divider.
// Reset clears only the stage valid bits; the datapath carries no state.
// A stall at the output freezes every stage at once, so nothing is dropped
// or repeated, and s_ready follows the output register's room.
// ----------------------------------------------------------------------------
`default_nettype none

module point_segment_distance_sq_unit
    import psd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_ax,
    input  logic signed [15:0] s_ay,
    input  logic signed [15:0] s_bx,
    input  logic signed [15:0] s_by,
    input  logic signed [15:0] s_px,
    input  logic signed [15:0] s_py,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [32:0]        m_dist_sq
);

    logic adv;

    // Stage 1 registers: endpoints ordered by x.
    logic               v1_reg;
    coord_t             x1_1_reg, y1_1_reg, x2_1_reg, y2_1_reg, qx_1_reg, qy_1_reg;
    logic [16:0]        dx_1_reg;
    logic signed [16:0] dy_1_reg, e_1_reg;

    // Stage 2 registers: products of the deltas.
    logic               v2_reg;
    coord_t             x1_2_reg, y1_2_reg, x2_2_reg, y2_2_reg, qx_2_reg, qy_2_reg;
    logic [16:0]        dx_2_reg;
    logic signed [16:0] dy_2_reg, e_2_reg;
    logic [31:0]        dx2_2_reg, dy2_2_reg;
    logic signed [33:0] dxdy_2_reg;

    // Stage 3 registers: denominator and numerator terms.
    logic               v3_reg;
    coord_t             x1_3_reg, y1_3_reg, x2_3_reg, y2_3_reg, qx_3_reg, qy_3_reg;
    logic [16:0]        dx_3_reg;
    logic signed [16:0] dy_3_reg;
    logic [32:0]        den_3_reg;
    logic signed [51:0] t1_3_reg, t2_3_reg, t3_3_reg;

    // Stage 4 registers: summed numerator.
    logic               v4_reg;
    coord_t             x1_4_reg, y1_4_reg, x2_4_reg, y2_4_reg, qx_4_reg, qy_4_reg;
    logic [16:0]        dx_4_reg;
    logic signed [16:0] dy_4_reg;
    logic [32:0]        den_4_reg;
    logic signed [51:0] num_4_reg;

    // Projection divider.
    psd_side1_t         side1_in, side1_out;
    logic [51:0]        num_mag;
    logic               d1_valid;
    logic [QUO1_W-1:0]  d1_quo;

    // Stage A registers: x clamp decided, second divide operands chosen.
    logic               va_reg;
    psd_side2_t         side_a_reg;
    logic signed [16:0] opa_a_reg;
    logic signed [17:0] opb_a_reg;
    logic [16:0]        dvs_a_reg;
    logic               dneg_a_reg;

    // Stage B registers: second divide product.
    logic               vb_reg;
    psd_side2_t         side_b_reg;
    logic signed [34:0] prod_b_reg;
    logic [16:0]        dvs_b_reg;
    logic               dneg_b_reg;

    // Second-axis divider.
    psd_side2_t         side2_in, side2_out;
    logic [34:0]        prod_mag;
    logic               d2_valid;
    logic [QUO2_W-1:0]  d2_quo;

    // Stage D, E, F and output registers.
    logic               vd_reg;
    psd_side2_t         side_d_reg;
    logic signed [18:0] y_d_reg;
    logic               ve_reg, degen_e_reg;
    logic signed [16:0] ex_e_reg, ey_e_reg;
    logic               vf_reg, degen_f_reg;
    logic [31:0]        sqx_f_reg, sqy_f_reg;
    logic               m_valid_reg;
    logic [32:0]        m_dist_sq_reg;

    // Every stage moves together whenever the output register has room.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Valid bits for the stages outside the dividers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            vd_reg      <= 1'b0;
            ve_reg      <= 1'b0;
            vf_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            va_reg      <= d1_valid;
            vb_reg      <= va_reg;
            vd_reg      <= d2_valid;
            ve_reg      <= vd_reg;
            vf_reg      <= ve_reg;
            m_valid_reg <= vf_reg;
        end
    end

    // Stage 1: order the endpoints by x; a tie keeps the given order.
    logic   swap;
    coord_t x1_in, y1_in, x2_in, y2_in;

    always_comb begin
        swap  = (s_ax > s_bx);
        x1_in = swap ? s_bx : s_ax;
        y1_in = swap ? s_by : s_ay;
        x2_in = swap ? s_ax : s_bx;
        y2_in = swap ? s_ay : s_by;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_1_reg <= x1_in;
            y1_1_reg <= y1_in;
            x2_1_reg <= x2_in;
            y2_1_reg <= y2_in;
            qx_1_reg <= s_px;
            qy_1_reg <= s_py;
            dx_1_reg <= 17'({x2_in[15], x2_in} - {x1_in[15], x1_in});
            dy_1_reg <= $signed({y2_in[15], y2_in}) - $signed({y1_in[15], y1_in});
            e_1_reg  <= $signed({s_py[15], s_py}) - $signed({y1_in[15], y1_in});
        end
    end

    // Stage 2: squares and cross product of the deltas.
    logic signed [33:0] dy2_full;
    logic signed [33:0] dxdy_full;

    always_comb begin
        dy2_full  = dy_1_reg * dy_1_reg;
        dxdy_full = $signed({1'b0, dx_1_reg}) * dy_1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_2_reg   <= x1_1_reg;
            y1_2_reg   <= y1_1_reg;
            x2_2_reg   <= x2_1_reg;
            y2_2_reg   <= y2_1_reg;
            qx_2_reg   <= qx_1_reg;
            qy_2_reg   <= qy_1_reg;
            dx_2_reg   <= dx_1_reg;
            dy_2_reg   <= dy_1_reg;
            e_2_reg    <= e_1_reg;
            dx2_2_reg  <= 32'(dx_1_reg * dx_1_reg);
            dy2_2_reg  <= dy2_full[31:0];
            dxdy_2_reg <= dxdy_full;
        end
    end

    // Stage 3: squared length and the three numerator products.
    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_3_reg  <= x1_2_reg;
            y1_3_reg  <= y1_2_reg;
            x2_3_reg  <= x2_2_reg;
            y2_3_reg  <= y2_2_reg;
            qx_3_reg  <= qx_2_reg;
            qy_3_reg  <= qy_2_reg;
            dx_3_reg  <= dx_2_reg;
            dy_3_reg  <= dy_2_reg;
            den_3_reg <= {1'b0, dx2_2_reg} + {1'b0, dy2_2_reg};
            t1_3_reg  <= e_2_reg * dxdy_2_reg;
            t2_3_reg  <= x1_2_reg * $signed({1'b0, dy2_2_reg});
            t3_3_reg  <= qx_2_reg * $signed({1'b0, dx2_2_reg});
        end
    end

    // Stage 4: sum the numerator.
    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_4_reg  <= x1_3_reg;
            y1_4_reg  <= y1_3_reg;
            x2_4_reg  <= x2_3_reg;
            y2_4_reg  <= y2_3_reg;
            qx_4_reg  <= qx_3_reg;
            qy_4_reg  <= qy_3_reg;
            dx_4_reg  <= dx_3_reg;
            dy_4_reg  <= dy_3_reg;
            den_4_reg <= den_3_reg;
            num_4_reg <= t1_3_reg + t2_3_reg + t3_3_reg;
        end
    end

    // The divider works on magnitudes; the sign is reapplied afterward.
    always_comb begin
        num_mag        = num_4_reg[51] ? 52'(-num_4_reg) : 52'(num_4_reg);
        side1_in.degen = (den_4_reg == '0);
        side1_in.neg   = num_4_reg[51];
        side1_in.x1    = x1_4_reg;
        side1_in.y1    = y1_4_reg;
        side1_in.x2    = x2_4_reg;
        side1_in.y2    = y2_4_reg;
        side1_in.qx    = qx_4_reg;
        side1_in.qy    = qy_4_reg;
        side1_in.dx    = dx_4_reg;
        side1_in.dy    = dy_4_reg;
    end

    psd_div #(
        .NUM_W  (NUM1_W),
        .DEN_W  (DEN1_W),
        .QUO_W  (QUO1_W),
        .SIDE_W ($bits(psd_side1_t))
    ) u_div_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v4_reg),
        .in_num    (num_mag[NUM1_W-1:0]),
        .in_den    (den_4_reg),
        .in_side   (side1_in),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_side  (side1_out)
    );

    // Stage A: clamp by x, and pick the dominant axis for y.
    logic signed [18:0] x_proj;
    logic signed [16:0] dy_abs;
    logic               use_x;
    psd_sel_t           sel_a;
    coord_t             x_mid;

    always_comb begin
        x_proj = side1_out.neg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});
        dy_abs = side1_out.dy[16] ? -side1_out.dy : side1_out.dy;
        use_x  = ($signed({1'b0, side1_out.dx}) > $signed({1'b0, dy_abs}));
        x_mid  = x_proj[15:0];
        if (x_proj < side1_out.x1) begin
            sel_a = SEL_LEFT;
        end else if (x_proj > side1_out.x2) begin
            sel_a = SEL_RIGHT;
        end else begin
            sel_a = SEL_MID;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_a_reg.degen <= side1_out.degen;
            side_a_reg.sel   <= sel_a;
            side_a_reg.use_x <= use_x;
            side_a_reg.neg   <= 1'b0;
            side_a_reg.x     <= x_mid;
            side_a_reg.x1    <= side1_out.x1;
            side_a_reg.y1    <= side1_out.y1;
            side_a_reg.x2    <= side1_out.x2;
            side_a_reg.y2    <= side1_out.y2;
            side_a_reg.qx    <= side1_out.qx;
            side_a_reg.qy    <= side1_out.qy;
            if (use_x) begin
                opa_a_reg  <= $signed({x_mid[15], x_mid}) - $signed({side1_out.x1[15],
                                                                     side1_out.x1});
                opb_a_reg  <= 18'(side1_out.dy);
                dvs_a_reg  <= side1_out.dx;
                dneg_a_reg <= 1'b0;
            end else begin
                opa_a_reg  <= $signed({x_mid[15], x_mid}) - $signed({side1_out.qx[15],
                                                                     side1_out.qx});
                opb_a_reg  <= $signed({1'b0, side1_out.dx});
                dvs_a_reg  <= 17'(dy_abs);
                dneg_a_reg <= side1_out.dy[16];
            end
        end
    end

    // Stage B: dividend of the second division.
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_b_reg <= side_a_reg;
            prod_b_reg <= opa_a_reg * opb_a_reg;
            dvs_b_reg  <= dvs_a_reg;
            dneg_b_reg <= dneg_a_reg;
        end
    end

    // Quotient sign is the dividend sign combined with the divisor sign.
    always_comb begin
        prod_mag     = prod_b_reg[34] ? 35'(-prod_b_reg) : 35'(prod_b_reg);
        side2_in     = side_b_reg;
        side2_in.neg = prod_b_reg[34] ^ dneg_b_reg;
    end

    psd_div #(
        .NUM_W  (NUM2_W),
        .DEN_W  (DEN2_W),
        .QUO_W  (QUO2_W),
        .SIDE_W ($bits(psd_side2_t))
    ) u_div_axis (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vb_reg),
        .in_num    (prod_mag[NUM2_W-1:0]),
        .in_den    (dvs_b_reg),
        .in_side   (side2_in),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_side  (side2_out)
    );

    // Stage D: derive y from the dominant axis.
    logic signed [18:0] q2_s;

    always_comb begin
        q2_s = side2_out.neg ? -$signed({2'b00, d2_quo}) : $signed({2'b00, d2_quo});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_d_reg <= side2_out;
            y_d_reg    <= side2_out.use_x ? (side2_out.y1 + q2_s) : (side2_out.qy - q2_s);
        end
    end

    // Stage E: clamp by y, then the offsets to the chosen point.
    coord_t fx, fy;
    coord_t lo_x, lo_y, hi_x, hi_y;

    always_comb begin
        if (side_d_reg.y1 > side_d_reg.y2) begin
            lo_x = side_d_reg.x2;
            lo_y = side_d_reg.y2;
            hi_x = side_d_reg.x1;
            hi_y = side_d_reg.y1;
        end else begin
            lo_x = side_d_reg.x1;
            lo_y = side_d_reg.y1;
            hi_x = side_d_reg.x2;
            hi_y = side_d_reg.y2;
        end
        case (side_d_reg.sel)
            SEL_LEFT: begin
                fx = side_d_reg.x1;
                fy = side_d_reg.y1;
            end
            SEL_RIGHT: begin
                fx = side_d_reg.x2;
                fy = side_d_reg.y2;
            end
            SEL_MID: begin
                if (y_d_reg < lo_y) begin
                    fx = lo_x;
                    fy = lo_y;
                end else if (y_d_reg > hi_y) begin
                    fx = hi_x;
                    fy = hi_y;
                end else begin
                    fx = side_d_reg.x;
                    fy = y_d_reg[15:0];
                end
            end
            default: begin
                fx = side_d_reg.x1;
                fy = side_d_reg.y1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degen_e_reg <= side_d_reg.degen;
            ex_e_reg    <= $signed({side_d_reg.qx[15], side_d_reg.qx}) - $signed({fx[15], fx});
            ey_e_reg    <= $signed({side_d_reg.qy[15], side_d_reg.qy}) - $signed({fy[15], fy});
        end
    end

    // Stage F: squared offsets.
    logic signed [33:0] sqx_full, sqy_full;

    always_comb begin
        sqx_full = ex_e_reg * ex_e_reg;
        sqy_full = ey_e_reg * ey_e_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            degen_f_reg <= degen_e_reg;
            sqx_f_reg   <= sqx_full[31:0];
            sqy_f_reg   <= sqy_full[31:0];
        end
    end

    // Output register; a degenerate segment reports zero.
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_dist_sq_reg <= degen_f_reg ? '0 : ({1'b0, sqx_f_reg} + {1'b0, sqy_f_reg});
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_dist_sq = m_dist_sq_reg;

`ifndef SYNTHESIS
    // The projected x always fits well inside the projection quotient.
    a_proj_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (d1_valid && !side1_out.degen) |-> (d1_quo[QUO1_W-1] == 1'b0))
        else $error("projection quotient out of range");

    // The derived-axis quotient never exceeds the coordinate span.
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (d2_valid && !side2_out.degen && side2_out.sel == SEL_MID)
            |-> (d2_quo[QUO2_W-1] == 1'b0))
        else $error("axis quotient out of range");

    // A result never exceeds the largest possible squared distance.
    a_dist_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dist_sq <= DIST_MAX))
        else $error("distance out of range");
`endif

endmodule

`default_nettype wire

/* dv/psd_checker.sv */
// ----------------------------------------------------------------------------
// psd_checker
// Watches both channels of the point to segment distance unit, predicts the
// squared distance of every accepted request and compares it with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_checker
    import psd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_ax,
    input  logic signed [15:0] s_ay,
    input  logic signed [15:0] s_bx,
    input  logic signed [15:0] s_by,
    input  logic signed [15:0] s_px,
    input  logic signed [15:0] s_py,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [32:0]        m_dist_sq,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DIST_W-1:0] dist_queue[$];

    assign pending = dist_queue.size();

    // Nearest point on the segment, clamped by x and then by y.
    function automatic logic [DIST_W-1:0] seg_dist_sq(
        input longint ax, input longint ay, input longint bx, input longint by,
        input longint px, input longint py);
        longint x1, y1, x2, y2, dx, dy, den, num, x, y, ex, ey, t;
        logic [63:0] sum;
        x1 = ax; y1 = ay; x2 = bx; y2 = by;
        if (x1 > x2) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        den = dy * dy + dx * dx;
        if (den == 0) return '0;
        num = (py - y1) * (dx * dy) + x1 * dy * dy + px * dx * dx;
        x = num / den;
        if (x < x1) begin
            x = x1; y = y1;
        end else if (x > x2) begin
            x = x2; y = y2;
        end else begin
            // Derive y along the dominant axis; a tie goes the y-axis way.
            if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy))
                y = y1 + ((x - x1) * dy) / dx;
            else
                y = py - ((x - px) * dx) / dy;
            if (y1 > y2) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            if (y < y1) begin
                y = y1; x = x1;
            end else if (y > y2) begin
                y = y2; x = x2;
            end
        end
        ex = px - x;
        ey = py - y;
        sum = ex * ex + ey * ey;
        return sum[DIST_W-1:0];
    endfunction

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge aclk) begin
        logic [DIST_W-1:0] want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                dist_queue = {dist_queue,
                              seg_dist_sq(s_ax, s_ay, s_bx, s_by, s_px, s_py)};
            if (m_valid && m_ready) begin
                if (dist_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected result: dist_sq=%0d", m_dist_sq);
                    fail_count <= fail_count + 1;
                end else begin
                    want = dist_queue.pop_front();
                    if (want !== m_dist_sq) begin
                        if (fail_count < 10)
                            $display("Mismatch dist_sq: expected %0d, got %0d",
                                     want, m_dist_sq);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random segment requests into the distance unit under
// bursty input and stalling output, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = 47;
    localparam int WDOG_MAX = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_ax = '0, s_ay = '0, s_bx = '0, s_by = '0;
    logic signed [15:0] s_px = '0, s_py = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [32:0] m_dist_sq;
    int fail_count, pending;
    int idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    point_segment_distance_sq_unit uut (.*);

    psd_checker checker_i (.*);

    // Receiver stall pattern: alternating calm and busy stretches.
    always @(posedge aclk) begin
        int phase;
        phase = int'(($time / 3000) % 3);
        if (phase == 0) m_ready <= 1'b1;
        else if (phase == 1) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 2) == 0);
    end

    // Watchdog on cycles with no handshake.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return $signed(16'($urandom_range(0, 40)) - 16'd20);
            default: return $signed(16'($urandom));
        endcase
    endfunction

    // Present one request and hold it until accepted.
    task automatic send_segment(input logic signed [15:0] ax, ay, bx, by, px, py);
        s_valid <= 1'b1;
        s_ax <= ax; s_ay <= ay; s_bx <= bx; s_by <= by; s_px <= px; s_py <= py;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random();
        logic signed [15:0] ax, ay, bx, by, px, py;
        ax = rand_coord(); ay = rand_coord(); px = rand_coord(); py = rand_coord();
        case ($urandom_range(0, 9))
            0: begin bx = ax; by = ay; end
            1: begin bx = ax; by = rand_coord(); end
            2: begin bx = rand_coord(); by = ay; end
            3: begin bx = ax + 16'(17); by = ay - 16'(17); end
            default: begin bx = rand_coord(); by = rand_coord(); end
        endcase
        send_segment(ax, ay, bx, by, px, py);
    endtask

    initial begin
        int gap;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, degenerate segments and the tie cases.
        send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_segment(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_segment(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
        send_segment(5, 5, 5, 5, 16'sh8000, 16'sh7fff);
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(10, 16'sh8000, 10, 16'sh7fff, 16'sh8000, 0);
        send_segment(10, 50, 10, -50, 20, 60);
        send_segment(-20, 7, 40, 7, 100, 16'sh7fff);
        send_segment(40, 7, -20, 7, -100, 16'sh8000);
        send_segment(0, 0, 30, 30, 10, 20);
        send_segment(30, -30, 0, 0, 40, -50);
        send_segment(0, 0, 100, 3, 50, 60);
        send_segment(0, 0, 3, 100, 60, 50);
        send_segment(-5, -5, 5, 5, -7, -9);
        send_segment(-5, -5, 5, 5, 9, 7);
        send_segment(16'sh7fff, 0, 16'sh8000, 1, 0, 16'sh7fff);
        send_segment(16'shffff, 16'shffff, 16'sh0001, 16'sh0001, 16'shaaaa, 16'sh5555);
        s_valid <= 1'b0;

        // Hold off until every outstanding result has drained.
        while (pending != 0) @(posedge aclk);

        // Random bursts with random gaps; valid drops only when a gap follows.
        for (int n = 0; n < 1400; ) begin
            for (int b = $urandom_range(1, 30); b > 0 && n < 1400; b--, n++)
                send_random();
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (gap == 0)
            s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
